[rtl/cpd_pkg.sv]
package cpd_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_GET_STATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_RESET       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_GET_VERSION = 3'd6;

    // reset values of the configuration registers
    localparam logic [7:0]  HEADER_FIRST_RST     = 8'h00;
    localparam logic [7:0]  HEADER_SECOND_RST    = 8'h00;
    localparam logic [15:0] MAX_PAYLOAD_RST      = 16'd1024;
    localparam logic [15:0] CRC_INIT_RST         = 16'hFFFF;
    localparam logic [7:0]  CODE_GET_STATE_RST   = 8'd0;
    localparam logic [7:0]  CODE_RESET_RST       = 8'd1;
    localparam logic [7:0]  CODE_GET_VERSION_RST = 8'd2;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        PH_HDR_FIRST  = 3'd0,
        PH_HDR_SECOND = 3'd1,
        PH_LEN_LO     = 3'd2,
        PH_LEN_HI     = 3'd3,
        PH_PAYLOAD    = 3'd4,
        PH_CRC_LO     = 3'd5,
        PH_CRC_HI     = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_GET_STATE   = 2'd0,
        KIND_RESET       = 2'd1,
        KIND_GET_VERSION = 2'd2,
        KIND_NONE        = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_INVALID = 2'd2
    } err_kind_t;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [15:0] max_payload;
        logic [15:0] crc_init;
        logic [7:0]  code_get_state;
        logic [7:0]  code_reset;
        logic [7:0]  code_get_version;
    } cpd_cfg_t;

    typedef struct packed {
        logic [7:0]  command_id;
        cmd_kind_t   command_kind;
        logic        accepted;
        err_kind_t   error_kind;
        logic [15:0] frame_length;
    } cpd_result_t;

    // crc-16, poly 0x1021, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/cpd_frame_fsm.sv]
module cpd_frame_fsm
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data,
    input  cpd_pkg::cpd_cfg_t    cfg,
    output logic                 res_valid,
    output cpd_pkg::cpd_result_t res
);

    cpd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  type_reg, type_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cpd_pkg::PH_HDR_FIRST;
            len_reg    <= '0;
            cnt_reg    <= '0;
            crc_reg    <= cpd_pkg::CRC_INIT_RST;
            crc_lo_reg <= '0;
            id_reg     <= '0;
            type_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            id_reg     <= id_next;
            type_reg   <= type_next;
        end
    end

    assign crc_upd  = cpd_pkg::crc16_byte(crc_reg, data);
    assign len_full = {data, len_reg[7:0]};
    assign cnt_inc  = cnt_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        id_next     = id_reg;
        type_next   = type_reg;
        res_valid   = 1'b0;
        res         = '{command_id: 8'h00, command_kind: cpd_pkg::KIND_NONE,
                        accepted: 1'b0, error_kind: cpd_pkg::ERR_SHORT,
                        frame_length: len_reg};

        unique case (phase_reg)
            cpd_pkg::PH_HDR_SECOND:
            begin
                if (data == cfg.header_second)
                begin
                    crc_next   = cfg.crc_init;
                    phase_next = cpd_pkg::PH_LEN_LO;
                end
                else if (data == cfg.header_first)
                    phase_next = cpd_pkg::PH_HDR_SECOND;
                else
                    phase_next = cpd_pkg::PH_HDR_FIRST;
            end
            cpd_pkg::PH_LEN_LO:
            begin
                len_next   = {8'h00, data};
                crc_next   = crc_upd;
                phase_next = cpd_pkg::PH_LEN_HI;
            end
            cpd_pkg::PH_LEN_HI:
            begin
                len_next = len_full;
                crc_next = crc_upd;
                if (len_full == 16'd0 || len_full > cfg.max_payload)
                    phase_next = cpd_pkg::PH_HDR_FIRST;
                else
                begin
                    cnt_next   = '0;
                    phase_next = cpd_pkg::PH_PAYLOAD;
                end
            end
            cpd_pkg::PH_PAYLOAD:
            begin
                if (cnt_reg == 16'd0)
                    id_next = data;
                else if (cnt_reg == 16'd1)
                    type_next = data;
                crc_next = crc_upd;
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg)
                    phase_next = cpd_pkg::PH_CRC_LO;
            end
            cpd_pkg::PH_CRC_LO:
            begin
                crc_lo_next = data;
                phase_next  = cpd_pkg::PH_CRC_HI;
            end
            cpd_pkg::PH_CRC_HI:
            begin
                phase_next = cpd_pkg::PH_HDR_FIRST;
                res_valid  = ({data, crc_lo_reg} == crc_reg);
                if (len_reg >= 16'd2)
                begin
                    res.command_id = id_reg;
                    res.accepted   = 1'b1;
                    res.error_kind = cpd_pkg::ERR_NONE;
                    // lower code registers win on overlap
                    if (type_reg == cfg.code_get_state)
                        res.command_kind = cpd_pkg::KIND_GET_STATE;
                    else if (type_reg == cfg.code_reset)
                        res.command_kind = cpd_pkg::KIND_RESET;
                    else if (type_reg == cfg.code_get_version)
                        res.command_kind = cpd_pkg::KIND_GET_VERSION;
                    else
                    begin
                        res.accepted   = 1'b0;
                        res.error_kind = cpd_pkg::ERR_INVALID;
                    end
                end
            end
            default:
            begin
                // first header hunt, also the unused phase code
                if (data == cfg.header_first)
                    phase_next = cpd_pkg::PH_HDR_SECOND;
                else
                    phase_next = cpd_pkg::PH_HDR_FIRST;
            end
        endcase
    end

endmodule

[rtl/cpd_out_stage.sv]
module cpd_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cpd_pkg::cpd_result_t load_data,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cpd_pkg::cpd_result_t out_data
);

    logic                 vld_reg, vld_next;
    cpd_pkg::cpd_result_t data_reg;

    assign free = !vld_reg || out_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (free)
            vld_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= load_data;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

[rtl/crc_packet_deframer_dispatch.sv]
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------------
// in       | input     | in_valid / in_ready  | rx_byte
// out      | output    | out_valid / out_ready| command_id, command_kind, accepted,
//          |           |                      | error_kind, frame_length
// cfg      | input     | cfg_wr_en            | cfg_addr, cfg_wdata
//
// one byte per cycle sustained while the output is not stalled: a beat is held in the
// input register, then the parser state, byte-wide crc update and dispatch decode settle
// into the output register; most bytes produce no out beat
// reset clears the config registers to their defaults and the parser to header hunt
// a stalled out beat only holds the pipe when the input register also holds a byte
module crc_packet_deframer_dispatch
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       command_id,
    output logic [1:0]                       command_kind,
    output logic                             accepted,
    output logic [1:0]                       error_kind,
    output logic [15:0]                      frame_length,

    input  logic                             cfg_wr_en,
    input  logic [cpd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [cpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // configuration registers
    cpd_pkg::cpd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first     <= cpd_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second    <= cpd_pkg::HEADER_SECOND_RST;
            cfg_reg.max_payload      <= cpd_pkg::MAX_PAYLOAD_RST;
            cfg_reg.crc_init         <= cpd_pkg::CRC_INIT_RST;
            cfg_reg.code_get_state   <= cpd_pkg::CODE_GET_STATE_RST;
            cfg_reg.code_reset       <= cpd_pkg::CODE_RESET_RST;
            cfg_reg.code_get_version <= cpd_pkg::CODE_GET_VERSION_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                cpd_pkg::REG_HEADER_FIRST:     cfg_reg.header_first     <= cfg_wdata[7:0];
                cpd_pkg::REG_HEADER_SECOND:    cfg_reg.header_second    <= cfg_wdata[7:0];
                cpd_pkg::REG_MAX_PAYLOAD:      cfg_reg.max_payload      <= cfg_wdata;
                cpd_pkg::REG_CRC_INIT:         cfg_reg.crc_init         <= cfg_wdata;
                cpd_pkg::REG_CODE_GET_STATE:   cfg_reg.code_get_state   <= cfg_wdata[7:0];
                cpd_pkg::REG_CODE_RESET:       cfg_reg.code_reset       <= cfg_wdata[7:0];
                cpd_pkg::REG_CODE_GET_VERSION: cfg_reg.code_get_version <= cfg_wdata[7:0];
                default:                       ;  // unused index, write dropped
            endcase
        end
    end

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       out_free;

    // the held byte moves on when the output register has room for a possible result
    assign advance  = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ready)
            in_vld_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    // frame parser, crc and dispatch decode
    logic                 res_valid;
    cpd_pkg::cpd_result_t res;

    cpd_frame_fsm u_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data      (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    cpd_pkg::cpd_result_t out_data;

    cpd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_data (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign command_id   = out_data.command_id;
    assign command_kind = out_data.command_kind;
    assign accepted     = out_data.accepted;
    assign error_kind   = out_data.error_kind;
    assign frame_length = out_data.frame_length;

    // status ok exactly when no error is flagged
    a_acc_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (error_kind == cpd_pkg::ERR_NONE)))
        else $error("accepted and error_kind disagree");

    // an accepted frame always names a known command
    a_acc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> (command_kind != cpd_pkg::KIND_NONE))
        else $error("accepted frame with unknown command kind");

    // zero-length frames never reach dispatch
    a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_length != 16'd0))
        else $error("dispatch with zero frame length");

    // a full input register facing a stalled output must back-pressure
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipe is blocked");

endmodule
